// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the line projection checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check at every clock edge outside reset
`define RPL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every clock edge, reset included
`define RPL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/rpl_pkg.sv
// ----------------------------------------------------------------------------
// rpl_pkg
// Widths, types, register codes and trig helpers for the line projector.
// ----------------------------------------------------------------------------
package rpl_pkg;

    localparam int COORD_BITS     = 10;
    localparam int COEF_FRAC_BITS = 14;

    localparam int CW   = COORD_BITS;
    localparam int F    = COEF_FRAC_BITS;
    localparam int CFW  = F + 2;
    localparam int PW   = CW + CFW;
    localparam int RW   = PW + 2;
    localparam int AW   = 9;
    localparam int SOW  = 12;
    localparam int DOW  = 13;
    localparam int ZW   = ((RW > DOW + F) ? RW : DOW + F) + 1;
    localparam int NW   = RW + 8;
    localparam int QB   = CW + 8;
    localparam int OW   = 16;
    localparam int PAW  = 5;
    localparam int CSH  = 16 - F;
    localparam int NV   = QB + 6;

    typedef logic signed [CW-1:0]  t_coord;
    typedef logic signed [CFW-1:0] t_coef;
    typedef logic signed [PW-1:0]  t_prod;
    typedef logic signed [RW-1:0]  t_rot;
    typedef logic signed [ZW-1:0]  t_zs;
    typedef logic [ZW-1:0]         t_mag;
    typedef logic [NW-1:0]         t_num;
    typedef logic [QB-1:0]         t_quo;
    typedef logic signed [OW-1:0]  t_scr;
    typedef logic [AW-1:0]         t_angle;
    typedef logic [9:0]            t_deg;

    typedef enum logic [PAW-3:0] {
        REG_ANGLE_X = 3'd0,
        REG_ANGLE_Y = 3'd1,
        REG_SCR_X   = 3'd2,
        REG_SCR_Y   = 3'd3,
        REG_DEPTH   = 3'd4
    } t_reg_idx;

    function automatic logic [16:0] sine_q16(input logic [6:0] d);
        logic [16:0] v;
        case (d)
            7'd0: v = 17'd0;          7'd1: v = 17'd1144;       7'd2: v = 17'd2287;
            7'd3: v = 17'd3430;       7'd4: v = 17'd4572;       7'd5: v = 17'd5712;
            7'd6: v = 17'd6850;       7'd7: v = 17'd7987;       7'd8: v = 17'd9121;
            7'd9: v = 17'd10252;      7'd10: v = 17'd11380;     7'd11: v = 17'd12505;
            7'd12: v = 17'd13626;     7'd13: v = 17'd14742;     7'd14: v = 17'd15855;
            7'd15: v = 17'd16962;     7'd16: v = 17'd18064;     7'd17: v = 17'd19161;
            7'd18: v = 17'd20252;     7'd19: v = 17'd21336;     7'd20: v = 17'd22415;
            7'd21: v = 17'd23486;     7'd22: v = 17'd24550;     7'd23: v = 17'd25607;
            7'd24: v = 17'd26656;     7'd25: v = 17'd27697;     7'd26: v = 17'd28729;
            7'd27: v = 17'd29753;     7'd28: v = 17'd30767;     7'd29: v = 17'd31772;
            7'd30: v = 17'd32768;     7'd31: v = 17'd33754;     7'd32: v = 17'd34729;
            7'd33: v = 17'd35693;     7'd34: v = 17'd36647;     7'd35: v = 17'd37590;
            7'd36: v = 17'd38521;     7'd37: v = 17'd39441;     7'd38: v = 17'd40348;
            7'd39: v = 17'd41243;     7'd40: v = 17'd42126;     7'd41: v = 17'd42995;
            7'd42: v = 17'd43852;     7'd43: v = 17'd44695;     7'd44: v = 17'd45525;
            7'd45: v = 17'd46341;     7'd46: v = 17'd47143;     7'd47: v = 17'd47930;
            7'd48: v = 17'd48703;     7'd49: v = 17'd49461;     7'd50: v = 17'd50203;
            7'd51: v = 17'd50931;     7'd52: v = 17'd51643;     7'd53: v = 17'd52339;
            7'd54: v = 17'd53020;     7'd55: v = 17'd53684;     7'd56: v = 17'd54332;
            7'd57: v = 17'd54963;     7'd58: v = 17'd55578;     7'd59: v = 17'd56175;
            7'd60: v = 17'd56756;     7'd61: v = 17'd57319;     7'd62: v = 17'd57865;
            7'd63: v = 17'd58393;     7'd64: v = 17'd58903;     7'd65: v = 17'd59396;
            7'd66: v = 17'd59870;     7'd67: v = 17'd60326;     7'd68: v = 17'd60764;
            7'd69: v = 17'd61183;     7'd70: v = 17'd61584;     7'd71: v = 17'd61966;
            7'd72: v = 17'd62328;     7'd73: v = 17'd62672;     7'd74: v = 17'd62997;
            7'd75: v = 17'd63303;     7'd76: v = 17'd63589;     7'd77: v = 17'd63856;
            7'd78: v = 17'd64104;     7'd79: v = 17'd64332;     7'd80: v = 17'd64540;
            7'd81: v = 17'd64729;     7'd82: v = 17'd64898;     7'd83: v = 17'd65048;
            7'd84: v = 17'd65177;     7'd85: v = 17'd65287;     7'd86: v = 17'd65376;
            7'd87: v = 17'd65446;     7'd88: v = 17'd65496;     7'd89: v = 17'd65526;
            7'd90: v = 17'd65536;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic t_coef sin_coef(input t_deg deg);
        t_deg              d;
        logic signed [18:0] v;
        logic signed [18:0] vr;
        d = (deg >= 10'd360) ? deg - 10'd360 : deg;
        if (d <= 10'd90) begin
            v = $signed({2'b00, sine_q16(d[6:0])});
        end else if (d <= 10'd180) begin
            v = $signed({2'b00, sine_q16(7'(10'd180 - d))});
        end else if (d <= 10'd270) begin
            v = -$signed({2'b00, sine_q16(7'(d - 10'd180))});
        end else begin
            v = -$signed({2'b00, sine_q16(7'(10'd360 - d))});
        end
        vr = v + $signed(19'((19'd1 << CSH) >> 1));
        return CFW'(vr >>> CSH);
    endfunction

    function automatic t_coef prod_round(input t_coef a, input t_coef b);
        logic signed [2*CFW-1:0] p;
        p = a * b;
        p = p + $signed((2*CFW)'(1) <<< (F - 1));
        return CFW'(p >>> F);
    endfunction

endpackage

// File: hw/rtl/rpl_if.sv
// ----------------------------------------------------------------------------
// rpl_seg_if / rpl_proj_if
// Valid/ready channels for line segments in and projected lines out.
// ----------------------------------------------------------------------------
interface rpl_seg_if import rpl_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord start_x;
    t_coord start_y;
    t_coord start_z;
    t_coord finish_x;
    t_coord finish_y;
    t_coord finish_z;

    modport source (
        output valid, start_x, start_y, start_z, finish_x, finish_y, finish_z,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, start_z, finish_x, finish_y, finish_z,
        output ready
    );
endinterface

interface rpl_proj_if import rpl_pkg::*; ();
    logic valid;
    logic ready;
    t_scr start_screen_x;
    t_scr start_screen_y;
    t_scr finish_screen_x;
    t_scr finish_screen_y;
    logic visible;

    modport source (
        output valid, start_screen_x, start_screen_y, finish_screen_x, finish_screen_y,
               visible,
        input  ready
    );
    modport sink (
        input  valid, start_screen_x, start_screen_y, finish_screen_x, finish_screen_y,
               visible,
        output ready
    );
endinterface

// File: hw/rtl/rotate_project_line_3d_top.sv
// ----------------------------------------------------------------------------
// rotate_project_line_3d_top
// Rotates both endpoints of a 3D line and projects them onto the screen.
// ----------------------------------------------------------------------------
// Usage:
//   i_seg carries one line segment per item; o_proj returns one item per
//   segment with four saturated screen coordinates and a visible flag. When
//   either endpoint is not in front of the viewer, visible is low and the
//   coordinates are zero.
//   Angles, screen offsets and depth offset are written over the APB port;
//   the user must write them only while no item is in flight; the block
//   does not enforce this. The trig coefficients pass the sine/cosine and
//   then the product registers. One item is accepted every cycle while the
//   skid buffer is empty: the path is a multiplier stage, two adder stages,
//   a magnitude stage, QB stages of a one-bit-per-stage restoring divider
//   (four dividers side by side) and a saturation stage.
//   A one-entry skid buffer holds a result when o_proj stalls; i_seg.ready
//   drops while it is full and the whole pipeline holds.
//   Reset clears the registers to zero and empties the pipeline and skid.
// ----------------------------------------------------------------------------
module rotate_project_line_3d_top
    import rpl_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [PAW-1:0] paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    rpl_seg_if.sink        i_seg,
    rpl_proj_if.source     o_proj
);

    localparam logic signed [ZW-1:0]   ZLIM   = -(ZW'(5) << F);
    localparam logic signed [QB+1:0]   SAT_HI = (QB+2)'(2**(OW-1) - 1);
    localparam logic signed [QB+1:0]   SAT_LO = -(QB+2)'(2**(OW-1));

    logic signed [SOW-1:0] r_scr_x, r_scr_y;
    logic signed [DOW-1:0] r_depth;
    t_angle                r_ang_x, r_ang_y;
    logic                  w_wr;

    t_coef c_sa, c_ca, c_sb, c_cb;
    t_coef r_sa, r_ca, r_sb, r_cb, r_sbsa, r_sbca, r_cbsa, r_cbca;

    logic          w_ce;
    logic [NV-1:0] r_v;

    t_coord r0_x [0:1];
    t_coord r0_y [0:1];
    t_coord r0_z [0:1];

    t_prod r1_xcb [0:1];
    t_prod r1_ysbsa [0:1];
    t_prod r1_zsbca [0:1];
    t_prod r1_yca [0:1];
    t_prod r1_zsa [0:1];
    t_prod r1_xsb [0:1];
    t_prod r1_ycbsa [0:1];
    t_prod r1_zcbca [0:1];

    t_rot r2_rx [0:1];
    t_rot r2_ry [0:1];
    t_rot r2_rz [0:1];

    t_zs  c_zs [0:1];
    t_zs  r3_zs [0:1];
    t_rot r3_nx [0:1];
    t_rot r3_ny [0:1];
    logic r3_ok [0:1];

    t_rot c_n [0:3];
    t_num c_num [0:3];
    t_mag c_den [0:1];

    t_mag r_rem [0:QB][0:3];
    t_quo r_nlo [0:QB][0:3];
    t_quo r_q   [0:QB][0:3];
    t_mag r_den [0:QB][0:1];
    logic r_neg [0:QB][0:3];
    logic r_vs  [0:QB];

    logic [ZW:0] c_trial [1:QB][0:3];
    logic        c_ge    [1:QB][0:3];
    t_mag        n_rem   [1:QB][0:3];

    logic signed [QB:0]   c_qs  [0:3];
    logic signed [QB+1:0] c_sum [0:3];
    t_scr                 c_sat [0:3];
    t_scr                 r_po [0:3];
    logic                 r_po_vis;
    t_scr                 r_sk [0:3];
    logic                 r_sk_vis;
    logic                 r_skid_v;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang_x <= '0;
            r_ang_y <= '0;
            r_scr_x <= '0;
            r_scr_y <= '0;
            r_depth <= '0;
        end else if (w_wr) begin
            case (t_reg_idx'(paddr[PAW-1:2]))
                REG_ANGLE_X: r_ang_x <= pwdata[AW-1:0];
                REG_ANGLE_Y: r_ang_y <= pwdata[AW-1:0];
                REG_SCR_X:   r_scr_x <= pwdata[SOW-1:0];
                REG_SCR_Y:   r_scr_y <= pwdata[SOW-1:0];
                REG_DEPTH:   r_depth <= pwdata[DOW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[PAW-1:2]))
            REG_ANGLE_X: prdata = 32'(r_ang_x);
            REG_ANGLE_Y: prdata = 32'(r_ang_y);
            REG_SCR_X:   prdata = 32'($unsigned(r_scr_x));
            REG_SCR_Y:   prdata = 32'($unsigned(r_scr_y));
            REG_DEPTH:   prdata = 32'($unsigned(r_depth));
            default:     prdata = '0;
        endcase
    end

    assign c_sa = sin_coef(10'(r_ang_x));
    assign c_ca = sin_coef(10'(r_ang_x) + 10'd90);
    assign c_sb = sin_coef(10'(r_ang_y));
    assign c_cb = sin_coef(10'(r_ang_y) + 10'd90);

    always_ff @(posedge i_clk) begin
        r_sa   <= c_sa;
        r_ca   <= c_ca;
        r_sb   <= c_sb;
        r_cb   <= c_cb;
        r_sbsa <= prod_round(r_sb, r_sa);
        r_sbca <= prod_round(r_sb, r_ca);
        r_cbsa <= prod_round(r_cb, r_sa);
        r_cbca <= prod_round(r_cb, r_ca);
    end

    assign w_ce        = !r_skid_v;
    assign i_seg.ready = w_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_ce) begin
            r_v <= {r_v[NV-2:0], i_seg.valid};
        end
    end

    always_comb begin
        for (int p = 0; p < 2; p++) begin
            c_zs[p] = ZW'(r2_rz[p]) - (ZW'(r_depth) <<< F);
        end
        c_n[0] = r3_nx[0];
        c_n[1] = r3_ny[0];
        c_n[2] = r3_nx[1];
        c_n[3] = r3_ny[1];
        for (int c = 0; c < 4; c++) begin
            c_num[c] = {(c_n[c][RW-1] ? RW'(-c_n[c]) : RW'(c_n[c])), 8'b0};
        end
        for (int p = 0; p < 2; p++) begin
            c_den[p] = r3_zs[p][ZW-1] ? ZW'(-r3_zs[p]) : ZW'(r3_zs[p]);
        end
        for (int k = 1; k <= QB; k++) begin
            for (int c = 0; c < 4; c++) begin
                c_trial[k][c] = {r_rem[k-1][c], r_nlo[k-1][c][QB-1]};
                c_ge[k][c]    = c_trial[k][c] >= {1'b0, r_den[k-1][c >> 1]};
                n_rem[k][c]   = c_ge[k][c]
                              ? ZW'(c_trial[k][c] - {1'b0, r_den[k-1][c >> 1]})
                              : ZW'(c_trial[k][c]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            c_qs[c]  = r_neg[QB][c] ? -$signed({1'b0, r_q[QB][c]})
                                    : $signed({1'b0, r_q[QB][c]});
            c_sum[c] = (QB+2)'(c_qs[c])
                     + (QB+2)'(((c & 1) == 0) ? r_scr_x : r_scr_y);
            if (c_sum[c] > SAT_HI) begin
                c_sat[c] = OW'(SAT_HI);
            end else if (c_sum[c] < SAT_LO) begin
                c_sat[c] = OW'(SAT_LO);
            end else begin
                c_sat[c] = OW'(c_sum[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r0_x[0] <= i_seg.start_x;
            r0_y[0] <= i_seg.start_y;
            r0_z[0] <= i_seg.start_z;
            r0_x[1] <= i_seg.finish_x;
            r0_y[1] <= i_seg.finish_y;
            r0_z[1] <= i_seg.finish_z;
            for (int p = 0; p < 2; p++) begin
                r1_xcb[p]   <= r0_x[p] * r_cb;
                r1_ysbsa[p] <= r0_y[p] * r_sbsa;
                r1_zsbca[p] <= r0_z[p] * r_sbca;
                r1_yca[p]   <= r0_y[p] * r_ca;
                r1_zsa[p]   <= r0_z[p] * r_sa;
                r1_xsb[p]   <= r0_x[p] * r_sb;
                r1_ycbsa[p] <= r0_y[p] * r_cbsa;
                r1_zcbca[p] <= r0_z[p] * r_cbca;

                r2_rx[p] <= RW'(r1_xcb[p]) + RW'(r1_ysbsa[p]) + RW'(r1_zsbca[p]);
                r2_ry[p] <= RW'(r1_yca[p]) - RW'(r1_zsa[p]);
                r2_rz[p] <= RW'(r1_ycbsa[p]) + RW'(r1_zcbca[p]) - RW'(r1_xsb[p]);

                r3_zs[p] <= c_zs[p];
                r3_ok[p] <= c_zs[p] < ZLIM;
                r3_nx[p] <= r2_rx[p];
                r3_ny[p] <= r2_ry[p];

                r_den[0][p] <= c_den[p];
            end
            r_vs[0] <= r3_ok[0] & r3_ok[1];
            for (int c = 0; c < 4; c++) begin
                r_rem[0][c] <= ZW'(c_num[c] >> QB);
                r_nlo[0][c] <= c_num[c][QB-1:0];
                r_q[0][c]   <= '0;
                r_neg[0][c] <= c_n[c][RW-1] ^ r3_zs[c >> 1][ZW-1];
            end
            for (int k = 1; k <= QB; k++) begin
                r_vs[k] <= r_vs[k-1];
                r_den[k][0] <= r_den[k-1][0];
                r_den[k][1] <= r_den[k-1][1];
                for (int c = 0; c < 4; c++) begin
                    r_rem[k][c] <= n_rem[k][c];
                    r_nlo[k][c] <= r_nlo[k-1][c] << 1;
                    r_q[k][c]   <= {r_q[k-1][c][QB-2:0], c_ge[k][c]};
                    r_neg[k][c] <= r_neg[k-1][c];
                end
            end
            for (int c = 0; c < 4; c++) begin
                r_po[c] <= r_vs[QB] ? c_sat[c] : '0;
            end
            r_po_vis <= r_vs[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_proj.ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (r_v[NV-1] && !o_proj.ready) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            r_sk     <= r_po;
            r_sk_vis <= r_po_vis;
        end
    end

    assign o_proj.valid           = r_skid_v | r_v[NV-1];
    assign o_proj.start_screen_x  = r_skid_v ? r_sk[0] : r_po[0];
    assign o_proj.start_screen_y  = r_skid_v ? r_sk[1] : r_po[1];
    assign o_proj.finish_screen_x = r_skid_v ? r_sk[2] : r_po[2];
    assign o_proj.finish_screen_y = r_skid_v ? r_sk[3] : r_po[3];
    assign o_proj.visible         = r_skid_v ? r_sk_vis : r_po_vis;

endmodule

// File: hw/rtl/rpl_chk.sv
// ----------------------------------------------------------------------------
// rpl_chk
// Port-level checks on the line projector's channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpl_chk
    import rpl_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_visible,
    input t_scr i_ssx,
    input t_scr i_ssy,
    input t_scr i_fsx,
    input t_scr i_fsy
);

    logic w_all_zero;
    logic w_in_hold;

    assign w_all_zero = (i_ssx == '0) && (i_ssy == '0) && (i_fsx == '0) && (i_fsy == '0);
    assign w_in_hold  = i_in_valid && !i_in_ready;

    `RPL_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid && i_in_ready, "reset left an item or a stall")
    `RPL_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "item dropped while stalled")
    `RPL_ASSERT(a_hidden_zero, i_clk, i_rst_n, i_out_valid && !i_visible |-> w_all_zero, "hidden line with nonzero coordinates")
    `RPL_ASSERT(a_stall_cause, i_clk, i_rst_n, w_in_hold |-> i_out_valid, "input held without a pending result")

endmodule

bind rotate_project_line_3d_top rpl_chk u_rpl_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_seg.valid),
    .i_in_ready  (i_seg.ready),
    .i_out_valid (o_proj.valid),
    .i_out_ready (o_proj.ready),
    .i_visible   (o_proj.visible),
    .i_ssx       (o_proj.start_screen_x),
    .i_ssy       (o_proj.start_screen_y),
    .i_fsx       (o_proj.finish_screen_x),
    .i_fsy       (o_proj.finish_screen_y)
);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for rotate_project_line_3d_top: a clocked driver and
// monitor, a bit-exact line projection predictor fed on acceptance, and APB
// register setup between phases while the pipeline is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import rpl_pkg::*;

    localparam int FRAC      = F;
    localparam int REG_COUNT = 5;
    localparam int DRAIN_CYC = QB + 15;
    localparam int SINE_TAB[91] = '{
        0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
        11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
        22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
        32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
        42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
        50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
        56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
        61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
        64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
        65536
    };

    typedef struct {
        t_coord sx, sy, sz, fx, fy, fz;
    } seg_t;

    typedef struct {
        t_scr ssx, ssy, fsx, fsy;
        logic vis;
    } line_t;

    logic           i_clk;
    logic           i_rst_n;
    logic           psel, penable, pwrite;
    logic [PAW-1:0] paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    rpl_seg_if  seg_ch ();
    rpl_proj_if proj_ch ();

    rotate_project_line_3d_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_seg   (seg_ch),
        .o_proj  (proj_ch)
    );

    t_angle               cfg_ax, cfg_ay;
    logic signed [SOW-1:0] cfg_sox, cfg_soy;
    logic signed [DOW-1:0] cfg_dep;

    seg_t  pending_segs[$];
    line_t expected_lines[$];
    int    idle_pct, stall_pct;
    int    mismatches;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint trig_q(int deg);
        longint v;
        int     sh;
        deg = deg % 360;
        if (deg <= 90) v = SINE_TAB[deg];
        else if (deg <= 180) v = SINE_TAB[180 - deg];
        else if (deg <= 270) v = -SINE_TAB[deg - 180];
        else v = -SINE_TAB[360 - deg];
        sh = 16 - FRAC;
        if (sh == 0) return v;
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint rnd_frac(longint p);
        return (p + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic line_t project_line(seg_t s);
        line_t  r;
        longint sa, ca, sb, cb, sbsa, sbca, cbsa, cbca, one;
        longint x, y, z, rx, ry, rz, zs;
        longint px[2], py[2];
        logic   ok;
        sa = trig_q(int'(cfg_ax));
        ca = trig_q(int'(cfg_ax) + 90);
        sb = trig_q(int'(cfg_ay));
        cb = trig_q(int'(cfg_ay) + 90);
        sbsa = rnd_frac(sb * sa);
        sbca = rnd_frac(sb * ca);
        cbsa = rnd_frac(cb * sa);
        cbca = rnd_frac(cb * ca);
        one = longint'(1) <<< FRAC;
        ok = 1'b1;
        for (int p = 0; p < 2; p++) begin
            x = (p == 0) ? s.sx : s.fx;
            y = (p == 0) ? s.sy : s.fy;
            z = (p == 0) ? s.sz : s.fz;
            rx = x * cb + y * sbsa + z * sbca;
            ry = y * ca - z * sa;
            rz = -x * sb + y * cbsa + z * cbca;
            zs = rz - longint'(cfg_dep) * one;
            px[p] = 0;
            py[p] = 0;
            if (zs < -5 * one) begin
                px[p] = clamp16((256 * rx) / zs + cfg_sox);
                py[p] = clamp16((256 * ry) / zs + cfg_soy);
            end else begin
                ok = 1'b0;
            end
        end
        r.vis = ok;
        r.ssx = ok ? t_scr'(px[0]) : '0;
        r.ssy = ok ? t_scr'(py[0]) : '0;
        r.fsx = ok ? t_scr'(px[1]) : '0;
        r.fsy = ok ? t_scr'(py[1]) : '0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        seg_t s;
        if (!i_rst_n) begin
            seg_ch.valid <= 1'b0;
        end else if (!seg_ch.valid || seg_ch.ready) begin
            if (pending_segs.size() != 0 && $urandom_range(99) >= idle_pct) begin
                s = pending_segs.pop_front();
                seg_ch.valid    <= 1'b1;
                seg_ch.start_x  <= s.sx;
                seg_ch.start_y  <= s.sy;
                seg_ch.start_z  <= s.sz;
                seg_ch.finish_x <= s.fx;
                seg_ch.finish_y <= s.fy;
                seg_ch.finish_z <= s.fz;
            end else begin
                seg_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) proj_ch.ready <= 1'b0;
        else proj_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        seg_t  s;
        line_t e;
        if (i_rst_n && seg_ch.valid && seg_ch.ready) begin
            s.sx = seg_ch.start_x;  s.sy = seg_ch.start_y;  s.sz = seg_ch.start_z;
            s.fx = seg_ch.finish_x; s.fy = seg_ch.finish_y; s.fz = seg_ch.finish_z;
            expected_lines.push_back(project_line(s));
        end
        if (i_rst_n && proj_ch.valid && proj_ch.ready) begin
            if (expected_lines.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item on o_proj");
            end else begin
                e = expected_lines.pop_front();
                if (proj_ch.start_screen_x !== e.ssx || proj_ch.start_screen_y !== e.ssy ||
                    proj_ch.finish_screen_x !== e.fsx || proj_ch.finish_screen_y !== e.fsy ||
                    proj_ch.visible !== e.vis) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d %0d %0d %0d v%0b got %0d %0d %0d %0d v%0b",
                                 e.ssx, e.ssy, e.fsx, e.fsy, e.vis,
                                 proj_ch.start_screen_x, proj_ch.start_screen_y,
                                 proj_ch.finish_screen_x, proj_ch.finish_screen_y,
                                 proj_ch.visible);
                end
            end
        end
    end

    task automatic apb_write(int idx, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PAW'(idx * 4);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ANGLE_X: cfg_ax  = data[AW-1:0];
            REG_ANGLE_Y: cfg_ay  = data[AW-1:0];
            REG_SCR_X:   cfg_sox = data[SOW-1:0];
            REG_SCR_Y:   cfg_soy = data[SOW-1:0];
            REG_DEPTH:   cfg_dep = data[DOW-1:0];
            default: ;
        endcase
    endtask

    task automatic setup(int ax, int ay, int sox, int soy, int dep);
        logic [31:0] junk;
        junk = $urandom();
        apb_write(REG_ANGLE_X, {junk[31:AW], AW'(ax)});
        apb_write(REG_ANGLE_Y, {junk[31:AW], AW'(ay)});
        apb_write(REG_SCR_X, {junk[31:SOW], SOW'(sox)});
        apb_write(REG_SCR_Y, {junk[31:SOW], SOW'(soy)});
        apb_write(REG_DEPTH, {junk[31:DOW], DOW'(dep)});
        apb_write(REG_COUNT + $urandom_range(2), $urandom());
    endtask

    task automatic add_seg(int sx, int sy, int sz, int fx, int fy, int fz);
        seg_t s;
        s.sx = t_coord'(sx); s.sy = t_coord'(sy); s.sz = t_coord'(sz);
        s.fx = t_coord'(fx); s.fy = t_coord'(fy); s.fz = t_coord'(fz);
        pending_segs.push_back(s);
    endtask

    task automatic add_random(int n);
        for (int i = 0; i < n; i++)
            add_seg($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    endtask

    task automatic drain();
        while (pending_segs.size() != 0 || seg_ch.valid || expected_lines.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        seg_ch.valid = 1'b0;
        seg_ch.start_x = '0;  seg_ch.start_y = '0;  seg_ch.start_z = '0;
        seg_ch.finish_x = '0; seg_ch.finish_y = '0; seg_ch.finish_z = '0;
        proj_ch.ready = 1'b0;
        cfg_ax = '0; cfg_ay = '0; cfg_sox = '0; cfg_soy = '0; cfg_dep = '0;
        idle_pct = 0; stall_pct = 0; mismatches = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: plain front-facing lines, origin and extremes
        add_seg(0, 0, -6, 0, 0, -5);
        add_seg(511, 511, -512, -512, -512, -512);
        add_seg(-512, 511, -6, 511, -512, -7);
        add_seg(0, 0, 0, 0, 0, 0);
        add_seg(100, -100, -512, 3, 4, 511);
        drain();

        // 45 degrees about y: shallow depth drives saturation
        setup(0, 45, 2047, -2048, 0);
        add_seg(-503, 511, -511, 511, -511, 503);
        add_seg(511, -512, 503, -503, 0, -511);
        add_seg(511, 0, 504, 10, 10, 1);
        add_random(100);
        drain();

        idle_pct = 65;
        setup(359, 359, -2048, 2047, 4095);
        add_seg(511, 511, 511, -512, -512, -512);
        add_random(250);
        drain();

        idle_pct = 0; stall_pct = 65;
        setup($urandom_range(511, 360), $urandom_range(511, 360),
              $urandom_range(4095) - 2048, $urandom_range(4095) - 2048, -4096);
        add_random(150);
        drain();

        idle_pct = 23; stall_pct = 23;
        setup($urandom_range(359), $urandom_range(359),
              $urandom_range(4095) - 2048, $urandom_range(4095) - 2048,
              $urandom_range(600));
        add_random(300);
        drain();

        idle_pct = 0; stall_pct = 0;
        setup(90, 180, 0, 0, 0);
        add_random(100);
        drain();

        for (int k = 0; k < 4; k++) begin
            idle_pct = (k % 2) ? 65 : 0;
            stall_pct = (k >= 2) ? 65 : 0;
            setup($urandom_range(511), $urandom_range(511),
                  $urandom_range(4095) - 2048, $urandom_range(4095) - 2048,
                  $urandom_range(40, 6));
            add_random(100);
            drain();
        end

        if (mismatches == 0 && expected_lines.size() == 0) begin
            $display("rotate_project_line_3d_top test passed");
        end else begin
            $display("rotate_project_line_3d_top test failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("rotate_project_line_3d_top test failed");
        $finish;
    end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/rpl_pkg.sv
hw/rtl/rpl_if.sv
hw/rtl/rotate_project_line_3d_top.sv
hw/rtl/rpl_chk.sv
tb/tb_top.sv
